// ----- src/orl_pkg.sv -----
package orl_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int POS_W      = 7;
    localparam int ID_W       = 32;
    localparam int COURSE_W   = 56;
    localparam int YEAR_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_INS_POS    = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_INS_END    = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_INS_FRONT  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEL_ID     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEL_POS    = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEL_COURSE = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [COURSE_W-1:0]    course;
        logic [YEAR_W-1:0]      year;
    } t_rec;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic                   read_select;
        logic [POS_W-1:0]       position;
        logic signed [ID_W-1:0] student_id;
        logic [COURSE_W-1:0]    course_code;
        logic [YEAR_W-1:0]      year_level;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_W-1:0]     entry_count;
        logic [COUNT_W-1:0]     removed_count;
        logic signed [ID_W-1:0] read_id;
        logic [COURSE_W-1:0]    read_course;
        logic [YEAR_W-1:0]      read_year;
    } t_rsp;

    // broadcast to every cell
    typedef struct packed {
        logic ins;   // open a gap at the insert position and fill it
        logic rot;   // rotate the list by one toward the front
        logic keep;  // rotation puts the head record back at the tail
    } t_cell_ctl;

endpackage

// ----- src/ordered_record_list_top.sv -----
// ordered list of up to CAPACITY records (id, course, year), kept dense in a
// chain of cells, cell 0 holding the front of the list.
// input channel: i_in_valid / o_in_stall with one request item in i_in_item.
// output channel: o_out_valid / i_out_stall with one result item per request.
// one request is worked on at a time; o_in_stall is high while it is busy.
// the path from accept to the result shown on o_out_valid:
//   rejected or trivial requests (full, bad position, empty, not found,
//   unused code) go straight to the result; inserts (all cells shift in
//   parallel) pass through the insert state first; read, delete by id,
//   delete at position, delete by course: the list is rotated once through
//   the chain, one record per cycle, dropping or capturing the head as it passes
// the next request is taken once the result is loaded.
// the result sits in an output register, so the next request is accepted
// while a result waits; a stalled result holds, and the request after it
// waits in its final cycle until the output register frees up.
// reset empties the list and drops any pending result; stored records are
// not cleared since only entries below the length are ever read.
module ordered_record_list_top
    import orl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] M_READ       = 2'd0;
    localparam logic [1:0] M_DEL_ID     = 2'd1;
    localparam logic [1:0] M_DEL_POS    = 2'd2;
    localparam logic [1:0] M_DEL_COURSE = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_mode, n_mode;
    t_req                r_req, n_req;
    logic [XW-1:0]       r_ins_pos, n_ins_pos;
    logic [CW-1:0]       r_len, n_len;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_last, n_last;
    logic                r_found, n_found;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]       r_removed, n_removed;
    t_rec                r_rd, n_rd;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    t_cell_ctl           w_ctl;
    t_rec                w_new;
    t_rec                w_rec   [CAPACITY];
    t_rec                w_left  [CAPACITY];
    t_rec                w_right [CAPACITY];
    logic                w_keep;
    logic [XW-1:0]       w_len_x;
    logic [XW-1:0]       w_pos_x;
    logic [XW-1:0]       w_rpos_x;
    logic                w_full;

    assign w_len_x  = XW'(r_len);
    assign w_pos_x  = XW'(i_in_item.position);
    assign w_rpos_x = XW'(r_req.position);
    assign w_full   = (r_len == CW'(CAPACITY));

    assign w_new.id     = r_req.student_id;
    assign w_new.course = r_req.course_code;
    assign w_new.year   = r_req.year_level;

    // decides whether the record at the head survives this rotation step
    always_comb begin
        case (r_mode)
            M_READ:       w_keep = 1'b1;
            M_DEL_POS:    w_keep = (XW'(r_k) != w_rpos_x);
            M_DEL_ID:     w_keep = r_found || (w_rec[0].id != r_req.student_id);
            M_DEL_COURSE: w_keep = (w_rec[0].course != r_req.course_code);
            default:      w_keep = 1'b1;
        endcase
    end

    assign w_ctl.ins  = (r_state == S_INS);
    assign w_ctl.rot  = (r_state == S_ROT);
    assign w_ctl.keep = w_keep;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_mid_l
                assign w_left[g] = w_rec[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right[g] = '0;
            end else begin : g_mid_r
                assign w_right[g] = w_rec[g+1];
            end

            orl_cell #(
                .IDX (g),
                .XW  (XW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (r_ins_pos),
                .i_len   (w_len_x),
                .i_new   (w_new),
                .i_head  (w_rec[0]),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_rec   (w_rec[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_req       = r_req;
        n_ins_pos   = r_ins_pos;
        n_len       = r_len;
        n_k         = r_k;
        n_last      = r_last;
        n_found     = r_found;
        n_status    = r_status;
        n_removed   = r_removed;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in_item;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_rd      = '0;
                    n_found   = 1'b0;
                    n_k       = '0;
                    n_last    = r_len - CW'(1);
                    n_ins_pos = '0;
                    n_state   = S_DONE;
                    if (i_in_item.read_select) begin
                        if (r_len == '0) begin
                            n_status = ST_EMPTY;
                        end else if (w_pos_x >= w_len_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_mode  = M_READ;
                            n_state = S_ROT;
                        end
                    end else begin
                        case (i_in_item.req_type)
                            REQ_INS_POS: begin
                                if (w_pos_x > w_len_x) begin
                                    n_status = ST_BAD_POS;
                                end else if (w_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_ins_pos = w_pos_x;
                                    n_state   = S_INS;
                                end
                            end
                            REQ_INS_END: begin
                                if (w_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_ins_pos = w_len_x;
                                    n_state   = S_INS;
                                end
                            end
                            REQ_INS_FRONT: begin
                                if (w_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_state = S_INS;
                                end
                            end
                            REQ_DEL_ID: begin
                                if (r_len == '0) begin
                                    n_status = ST_NOT_FOUND;
                                end else begin
                                    n_mode  = M_DEL_ID;
                                    n_state = S_ROT;
                                end
                            end
                            REQ_DEL_POS: begin
                                if (r_len == '0) begin
                                    n_status = ST_EMPTY;
                                end else if (w_pos_x >= w_len_x) begin
                                    n_status = ST_BAD_POS;
                                end else begin
                                    n_mode  = M_DEL_POS;
                                    n_state = S_ROT;
                                end
                            end
                            REQ_DEL_COURSE: begin
                                if (r_len == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    n_mode  = M_DEL_COURSE;
                                    n_state = S_ROT;
                                end
                            end
                            default: begin
                                n_status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_INS: begin
                n_len   = r_len + CW'(1);
                n_state = S_DONE;
            end
            S_ROT: begin
                if (!w_keep) begin
                    n_len     = r_len - CW'(1);
                    n_removed = r_removed + CW'(1);
                    n_found   = 1'b1;
                end
                if ((r_mode == M_READ) && (XW'(r_k) == w_rpos_x)) begin
                    n_rd = w_rec[0];
                end
                n_k = r_k + CW'(1);
                if (r_k == r_last) begin
                    n_state = S_DONE;
                    if ((r_mode == M_DEL_ID) && !(r_found || !w_keep)) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.entry_count   = COUNT_W'(r_len);
                    n_out.removed_count = COUNT_W'(r_removed);
                    n_out.read_id       = r_rd.id;
                    n_out.read_course   = r_rd.course;
                    n_out.read_year     = r_rd.year;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_req     <= n_req;
        r_ins_pos <= n_ins_pos;
        r_k       <= n_k;
        r_last    <= n_last;
        r_found   <= n_found;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_rd      <= n_rd;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/orl_cell.sv -----
module orl_cell
    import orl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int XW  = 7
) (
    input  logic           i_clk,
    input  t_cell_ctl      i_ctl,
    input  logic [XW-1:0]  i_pos,
    input  logic [XW-1:0]  i_len,
    input  t_rec           i_new,
    input  t_rec           i_head,
    input  t_rec           i_left,
    input  t_rec           i_right,
    output t_rec           o_rec
);

    localparam logic [XW-1:0] K  = XW'(IDX);
    localparam logic [XW-1:0] K1 = XW'(IDX + 1);

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins) begin
            if (K == i_pos) begin
                n_rec = i_new;
            end else if ((K > i_pos) && (K <= i_len)) begin
                n_rec = i_left;
            end
        end else if (i_ctl.rot) begin
            if (K1 < i_len) begin
                n_rec = i_right;
            end else if ((K1 == i_len) && i_ctl.keep) begin
                // tail slot takes the record leaving the head
                n_rec = i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule
